@@ design/sqlo_pkg.sv @@
// Shared types, character codes and scanner states for the SQL literal obfuscator.
package sqlo_pkg;

	// Character codes that the scanner recognizes or produces.
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Output queue geometry.
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = 2;
	localparam int unsigned Q_CNT_W = 3;

	// Scanner states, one-hot.
	typedef enum logic [12:0] {
		ST_NORMAL     = 13'b0_0000_0000_0001,
		ST_DQ         = 13'b0_0000_0000_0010,
		ST_DQ_ESC     = 13'b0_0000_0000_0100,
		ST_DQ_QUOTE   = 13'b0_0000_0000_1000,
		ST_SQ         = 13'b0_0000_0001_0000,
		ST_SQ_ESC     = 13'b0_0000_0010_0000,
		ST_SQ_QUOTE   = 13'b0_0000_0100_0000,
		ST_DIGITS     = 13'b0_0000_1000_0000,
		ST_DASH       = 13'b0_0001_0000_0000,
		ST_SLASH      = 13'b0_0010_0000_0000,
		ST_LINE       = 13'b0_0100_0000_0000,
		ST_BLOCK      = 13'b0_1000_0000_0000,
		ST_BLOCK_STAR = 13'b1_0000_0000_0000
	} scan_state_t;

	// One result character with its flags.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       out_last;
	} res_t;

	// Results produced by one input byte, in order.
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} scan_out_t;

	// True for the decimal digits.
	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

@@ design/sql_literal_obfuscator.sv @@
// Top level of the SQL literal obfuscator: input stage, scanner and output queue.
//
// The block takes one SQL byte per request on s_axis and returns the statement with
// string and number literals replaced by '?' and comments removed. It accepts one byte
// every cycle while the queue has room; a byte enters the input register, is scanned
// there and its results (none, one or two) land in a four-entry output queue, whose
// registered head is offered on m_axis. The input stage moves on whenever the queue
// has room for two results; input stalls only after bytes that yield two characters
// pile up or the output side stalls. m_axis_tuser is 0 on an empty end marker,
// which appears when the final byte of a statement yields no character.
module sql_literal_obfuscator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,   // in_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [0:0] m_axis_tuser,   // [0] out_valid
	output logic       m_axis_tlast    // out_last
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                last_s1;
	logic                room;
	logic                step;
	sqlo_pkg::scan_out_t scan_res;
	sqlo_pkg::res_t      rd;

	assign step          = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Scanner.
	sqlo_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.res     (scan_res)
	);

	// Output queue.
	sqlo_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (step),
		.wr       (scan_res),
		.room     (room),
		.rd_valid (m_axis_tvalid),
		.rd_ready (m_axis_tready),
		.rd       (rd)
	);

	assign m_axis_tdata = rd.out_byte;
	assign m_axis_tuser = rd.out_valid;
	assign m_axis_tlast = rd.out_last;

	// A stalled input stage holds its byte.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !room |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("input stage lost a stalled byte");

	// Ready is low only while a byte waits for queue room.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && !room)
		else $error("input stalled without cause");

	// An output result is only offered when the queue holds one.
	a_out_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(step))
		else $error("output appeared without a processed byte");

endmodule

@@ design/sqlo_scan.sv @@
// Scanner state register and the per-byte redaction logic.
module sqlo_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           in_byte,
	input  logic                 in_last,
	output sqlo_pkg::scan_out_t  res
);

	sqlo_pkg::scan_state_t state_q;
	sqlo_pkg::scan_state_t state_d;

	// Results and next state for the byte held in the input stage.
	always_comb begin
		logic                  t_en;
		logic [7:0]            t_byte;
		sqlo_pkg::scan_state_t t_next;
		logic                  use_text;
		logic                  h_en;
		logic [7:0]            h_byte;
		logic                  f_en;
		logic [7:0]            f_byte;
		sqlo_pkg::scan_state_t nxt;
		logic [1:0]            n;

		// Handling of the byte as normal text.
		t_en   = 1'b1;
		t_byte = in_byte;
		t_next = sqlo_pkg::ST_NORMAL;
		priority if (in_byte == sqlo_pkg::CH_DQUOTE) begin
			t_byte = sqlo_pkg::CH_QMARK;
			t_next = sqlo_pkg::ST_DQ;
		end else if (in_byte == sqlo_pkg::CH_SQUOTE) begin
			t_byte = sqlo_pkg::CH_QMARK;
			t_next = sqlo_pkg::ST_SQ;
		end else if (in_byte == sqlo_pkg::CH_DASH) begin
			t_en   = 1'b0;
			t_next = sqlo_pkg::ST_DASH;
		end else if (in_byte == sqlo_pkg::CH_SLASH) begin
			t_en   = 1'b0;
			t_next = sqlo_pkg::ST_SLASH;
		end else if (sqlo_pkg::is_digit(in_byte)) begin
			t_byte = sqlo_pkg::CH_QMARK;
			t_next = sqlo_pkg::ST_DIGITS;
		end else begin
			t_next = sqlo_pkg::ST_NORMAL;
		end

		// State transition; a held dash or slash is released before the text byte.
		use_text = 1'b0;
		h_en     = 1'b0;
		h_byte   = sqlo_pkg::CH_DASH;
		nxt      = state_q;
		unique case (state_q)
			sqlo_pkg::ST_DQ: begin
				nxt = (in_byte == sqlo_pkg::CH_BSLASH) ? sqlo_pkg::ST_DQ_ESC :
				      (in_byte == sqlo_pkg::CH_DQUOTE) ? sqlo_pkg::ST_DQ_QUOTE : sqlo_pkg::ST_DQ;
			end
			sqlo_pkg::ST_DQ_ESC: begin
				nxt = sqlo_pkg::ST_DQ;
			end
			sqlo_pkg::ST_DQ_QUOTE: begin
				if (in_byte == sqlo_pkg::CH_DQUOTE) nxt = sqlo_pkg::ST_DQ;
				else use_text = 1'b1;
			end
			sqlo_pkg::ST_SQ: begin
				nxt = (in_byte == sqlo_pkg::CH_BSLASH) ? sqlo_pkg::ST_SQ_ESC :
				      (in_byte == sqlo_pkg::CH_SQUOTE) ? sqlo_pkg::ST_SQ_QUOTE : sqlo_pkg::ST_SQ;
			end
			sqlo_pkg::ST_SQ_ESC: begin
				nxt = sqlo_pkg::ST_SQ;
			end
			sqlo_pkg::ST_SQ_QUOTE: begin
				if (in_byte == sqlo_pkg::CH_SQUOTE) nxt = sqlo_pkg::ST_SQ;
				else use_text = 1'b1;
			end
			sqlo_pkg::ST_DIGITS: begin
				if (sqlo_pkg::is_digit(in_byte)) nxt = sqlo_pkg::ST_DIGITS;
				else use_text = 1'b1;
			end
			sqlo_pkg::ST_DASH: begin
				if (in_byte == sqlo_pkg::CH_DASH) begin
					nxt = sqlo_pkg::ST_LINE;
				end else begin
					h_en     = 1'b1;
					h_byte   = sqlo_pkg::CH_DASH;
					use_text = 1'b1;
				end
			end
			sqlo_pkg::ST_SLASH: begin
				if (in_byte == sqlo_pkg::CH_STAR) begin
					nxt = sqlo_pkg::ST_BLOCK_STAR;
				end else begin
					h_en     = 1'b1;
					h_byte   = sqlo_pkg::CH_SLASH;
					use_text = 1'b1;
				end
			end
			sqlo_pkg::ST_LINE: begin
				nxt = (in_byte == sqlo_pkg::CH_NL) ? sqlo_pkg::ST_NORMAL : sqlo_pkg::ST_LINE;
			end
			sqlo_pkg::ST_BLOCK: begin
				nxt = (in_byte == sqlo_pkg::CH_STAR) ? sqlo_pkg::ST_BLOCK_STAR : sqlo_pkg::ST_BLOCK;
			end
			sqlo_pkg::ST_BLOCK_STAR: begin
				nxt = (in_byte == sqlo_pkg::CH_SLASH) ? sqlo_pkg::ST_NORMAL :
				      (in_byte == sqlo_pkg::CH_STAR)  ? sqlo_pkg::ST_BLOCK_STAR :
				                                        sqlo_pkg::ST_BLOCK;
			end
			default: begin
				use_text = 1'b1;
			end
		endcase
		if (use_text) nxt = t_next;

		// A dash or slash still held on the final byte is flushed.
		f_en   = in_last && ((nxt == sqlo_pkg::ST_DASH) || (nxt == sqlo_pkg::ST_SLASH));
		f_byte = (nxt == sqlo_pkg::ST_DASH) ? sqlo_pkg::CH_DASH : sqlo_pkg::CH_SLASH;

		// Pack the emitted characters into the first two result slots.
		n      = 2'd0;
		res.r0 = '{out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b0};
		res.r1 = '{out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b0};
		if (h_en) begin
			res.r0 = '{out_byte: h_byte, out_valid: 1'b1, out_last: 1'b0};
			n      = 2'd1;
		end
		if (use_text && t_en) begin
			if (n == 2'd0) res.r0 = '{out_byte: t_byte, out_valid: 1'b1, out_last: 1'b0};
			else res.r1 = '{out_byte: t_byte, out_valid: 1'b1, out_last: 1'b0};
			n = n + 2'd1;
		end
		if (f_en && (n != 2'd2)) begin
			if (n == 2'd0) res.r0 = '{out_byte: f_byte, out_valid: 1'b1, out_last: 1'b0};
			else res.r1 = '{out_byte: f_byte, out_valid: 1'b1, out_last: 1'b0};
			n = n + 2'd1;
		end

		// The final byte always yields a result, an empty end marker if nothing else.
		if (in_last) begin
			if (n == 2'd0) n = 2'd1;
			if (n == 2'd2) res.r1.out_last = 1'b1;
			else res.r0.out_last = 1'b1;
		end
		res.cnt = n;

		state_d = in_last ? sqlo_pkg::ST_NORMAL : nxt;
	end

	// Scanner state advances once per processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sqlo_pkg::ST_NORMAL;
		end else if (step) begin
			state_q <= state_d;
		end
	end

	// The state register stays one-hot.
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("scanner state not one-hot");

	// A processed final byte returns the scanner to normal text.
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		step && in_last |=> state_q == sqlo_pkg::ST_NORMAL)
		else $error("scanner did not return to normal text after final byte");

	// A final byte always yields at least one result.
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		step && in_last |-> res.cnt != 2'd0)
		else $error("final byte produced no result");

endmodule

@@ design/sqlo_queue.sv @@
// Four-entry output queue that takes up to two results per cycle.
module sqlo_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sqlo_pkg::scan_out_t wr,
	output logic                room,
	output logic                rd_valid,
	input  logic                rd_ready,
	output sqlo_pkg::res_t      rd
);

	sqlo_pkg::res_t                  mem_q [sqlo_pkg::Q_DEPTH];
	logic [sqlo_pkg::Q_PTR_W-1:0]    wr_ptr_q;
	logic [sqlo_pkg::Q_PTR_W-1:0]    rd_ptr_q;
	logic [sqlo_pkg::Q_CNT_W-1:0]    count_q;
	logic [1:0]                      push_cnt;
	logic                            pop;

	assign push_cnt = push ? wr.cnt : 2'd0;
	assign pop      = rd_valid && rd_ready;
	assign rd_valid = (count_q != '0);
	assign rd       = mem_q[rd_ptr_q];
	// Room for a byte's worst case of two results.
	assign room     = (count_q <= sqlo_pkg::Q_CNT_W'(sqlo_pkg::Q_DEPTH - 2));

	// Result storage.
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) mem_q[wr_ptr_q] <= wr.r0;
		if (push_cnt == 2'd2) mem_q[wr_ptr_q + 1'b1] <= wr.r1;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + sqlo_pkg::Q_PTR_W'(push_cnt);
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + sqlo_pkg::Q_CNT_W'(push_cnt) - sqlo_pkg::Q_CNT_W'(pop);
		end
	end

	// The fill count never passes the depth.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sqlo_pkg::Q_CNT_W'(sqlo_pkg::Q_DEPTH))
		else $error("output queue overflow");

	// Pushes only happen when room was signaled.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_cnt != 2'd0 |-> room)
		else $error("push into queue without room");

	// Pointer distance matches the fill count when not full.
	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < sqlo_pkg::Q_CNT_W'(sqlo_pkg::Q_DEPTH) |->
		sqlo_pkg::Q_PTR_W'(wr_ptr_q - rd_ptr_q) == count_q[sqlo_pkg::Q_PTR_W-1:0])
		else $error("queue pointers disagree with fill count");

endmodule
